FILE: hdl/pgcb_pkg.sv
`default_nettype none
package pgcb_pkg;
    localparam int NUM_ROWS_DEF = 256;
    localparam int NUM_COLS_DEF = 256;
    localparam int CELLS = 65536;
    localparam int BOUNDS = 256;
    localparam logic [35:0] SUM_MAX = 36'h7_FFFF_FFFF;
    localparam logic [35:0] SUM_MIN = 36'h8_0000_0000;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_BIN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZLIM  = 2'd1;
    localparam logic [1:0] ST_COL   = 2'd2;
    localparam logic [1:0] ST_INDEX = 2'd3;

    localparam logic [2:0] REG_MIN_Y = 3'd0;
    localparam logic [2:0] REG_COL_W = 3'd1;
    localparam logic [2:0] REG_ROWS  = 3'd2;
    localparam logic [2:0] REG_ZLIM  = 3'd3;

    typedef struct packed {
        logic [15:0] count;
        logic [19:0] min_x;
        logic [19:0] max_x;
        logic [19:0] min_y;
        logic [19:0] max_y;
        logic [19:0] min_z;
        logic [19:0] max_z;
        logic [35:0] sum_x;
        logic [35:0] sum_z;
    } cell_t;

    typedef struct packed {
        logic        start;
        logic [20:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [20:0] quotient;
    } div_rsp_t;
endpackage
`default_nettype wire

FILE: hdl/pgcb_div.sv
`default_nettype none
module pgcb_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pgcb_pkg::div_req_t req,
    output pgcb_pkg::div_rsp_t     rsp
);
    import pgcb_pkg::*;

    logic [20:0] quo_reg;
    logic [16:0] rem_reg;
    logic [15:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic [17:0] diff;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        trial = {rem_reg[15:0], quo_reg[20]};
        diff  = {1'b0, trial} - {2'b00, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !req.start && (cnt_reg == 5'd1);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd21;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_reg <= diff[16:0];
                quo_reg <= {quo_reg[19:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[19:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule
`default_nettype wire

FILE: hdl/pgcb_cell_mem.sv
`default_nettype none
module pgcb_cell_mem #(
    parameter int DEPTH = pgcb_pkg::CELLS,
    parameter int AW = $clog2(DEPTH)
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire pgcb_pkg::cell_t wdata,
    input  wire logic [AW-1:0]   raddr,
    output pgcb_pkg::cell_t      rdata
);
    import pgcb_pkg::*;

    cell_t mem [DEPTH];
    cell_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

FILE: hdl/point_grid_cell_binner_top.sv
`default_nettype none
// Point grid binner. One word at a time: a new input is taken only after the
// previous result has been taken with out_ready high. A point bin overlaps the
// serial column divider with a linear scan of the row boundary memory (one
// boundary a cycle, up to row_count boundaries, at most NUM_ROWS and 256). After
// reset a clearing pass writes every cell empty, one cell a cycle
// (NUM_ROWS*NUM_COLS cells, 65536 by default, capped at 65536), while
// in_ready stays low; configuration writes are taken throughout.
module point_grid_cell_binner_top #(
    parameter int NUM_ROWS = pgcb_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLS = pgcb_pkg::NUM_COLS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [19:0] x_mm,
    input  wire logic [19:0] y_mm,
    input  wire logic [19:0] z_mm,
    input  wire logic [7:0]  row_select,
    input  wire logic [7:0]  col_select,
    input  wire logic [18:0] boundary_mm,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [15:0]      cell_address,
    output logic [15:0]      point_count,
    output logic [19:0]      min_x_out,
    output logic [19:0]      max_x_out,
    output logic [19:0]      min_y_out,
    output logic [19:0]      max_y_out,
    output logic [19:0]      min_z_out,
    output logic [19:0]      max_z_out,
    output logic [35:0]      sum_x_out,
    output logic [35:0]      sum_z_out
);
    import pgcb_pkg::*;

    localparam int NROWS = (NUM_ROWS < BOUNDS) ? NUM_ROWS : BOUNDS;
    localparam int NCELLS_RAW = NUM_ROWS * NUM_COLS;
    localparam int NCELLS = (NCELLS_RAW < CELLS) ? NCELLS_RAW : CELLS;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SEARCH, S_READ, S_WAIT, S_MODIFY, S_OUT
    } state_t;

    // configuration
    logic [19:0] min_y_reg;
    logic [15:0] colw_reg;
    logic [8:0]  rows_reg;
    logic [18:0] zlim_reg;
    logic [2:0]  reg_idx;

    assign reg_idx = paddr[3:2] == 2'd0 ? REG_MIN_Y :
                     paddr[3:2] == 2'd1 ? REG_COL_W :
                     paddr[3:2] == 2'd2 ? REG_ROWS : REG_ZLIM;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_y_reg <= '0;
            colw_reg  <= 16'd100;
            rows_reg  <= '0;
            zlim_reg  <= 19'd300000;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_MIN_Y: min_y_reg <= pwdata[19:0];
                REG_COL_W: colw_reg  <= pwdata[15:0];
                REG_ROWS:  rows_reg  <= pwdata[8:0];
                REG_ZLIM:  zlim_reg  <= pwdata[18:0];
                default:   min_y_reg <= min_y_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_Y: prdata = {12'd0, min_y_reg};
            REG_COL_W: prdata = {16'd0, colw_reg};
            REG_ROWS:  prdata = {23'd0, rows_reg};
            REG_ZLIM:  prdata = {13'd0, zlim_reg};
            default:   prdata = '0;
        endcase
    end

    // boundary memory
    logic [18:0] bnd_mem [BOUNDS];
    logic [18:0] bnd_rd_reg;
    logic [7:0]  bnd_raddr;
    logic        bnd_we;

    // state
    state_t      state_reg;
    logic [15:0] clr_reg;
    logic [1:0]  op_reg;
    logic [19:0] x_reg, y_reg, z_reg;
    logic [7:0]  rsel_reg, csel_reg;
    logic [8:0]  idx_reg;      // boundary now addressed (read address)
    logic        bval_ok_reg;  // boundary read data valid
    logic        found_reg;
    logic [8:0]  row_reg;
    logic        srch_done_reg;
    logic        div_done_reg;
    logic [20:0] col_q_reg;
    logic        col_neg_ok_reg;
    logic [15:0] addr_reg;
    logic [1:0]  st_reg;
    cell_t       res_reg;
    logic        res_zero_reg;
    logic        out_valid_reg;
    logic [8:0]  nsearch;

    assign nsearch = (rows_reg > 9'(NROWS)) ? 9'(NROWS) : rows_reg;
    assign bnd_we = (state_reg == S_IDLE) && in_valid && operation == OP_LOAD
                    && ({1'b0, row_select} < 9'(NROWS));
    assign bnd_raddr = idx_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (bnd_we)
        begin
            bnd_mem[row_select] <= boundary_mm;
        end
        bnd_rd_reg <= bnd_mem[bnd_raddr];
    end

    // column arithmetic
    logic signed [20:0] diff_s;
    logic [20:0]        neg_diff;
    assign diff_s   = $signed({y_reg[19], y_reg}) - $signed({min_y_reg[19], min_y_reg});
    assign neg_diff = 21'd0 - diff_s;

    div_req_t dreq;
    div_rsp_t drsp;
    assign dreq.start    = (state_reg == S_SEARCH) && (idx_reg == 9'd0) && !bval_ok_reg;
    assign dreq.dividend = diff_s[20] ? 21'd0 : diff_s;
    assign dreq.divisor  = (colw_reg == 16'd0) ? 16'd1 : colw_reg;

    pgcb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // cell memory
    logic        cm_we;
    logic [15:0] cm_waddr;
    cell_t       cm_wdata;
    logic [15:0] cm_raddr;
    cell_t       cm_rdata;

    pgcb_cell_mem #(.DEPTH(CELLS), .AW(16)) u_cells (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

    // read-modify of the cell
    cell_t  upd;
    logic [35:0] sx, sz;
    logic [36:0] ax, az;
    logic [35:0] xe, ze;
    always_comb
    begin
        xe = {{16{x_reg[19]}}, x_reg};
        ze = {{16{z_reg[19]}}, z_reg};
        ax = {cm_rdata.sum_x[35], cm_rdata.sum_x} + {xe[35], xe};
        az = {cm_rdata.sum_z[35], cm_rdata.sum_z} + {ze[35], ze};
        sx = (ax[36] != ax[35]) ? (ax[36] ? SUM_MIN : SUM_MAX) : ax[35:0];
        sz = (az[36] != az[35]) ? (az[36] ? SUM_MIN : SUM_MAX) : az[35:0];
        if (cm_rdata.count == 16'd0)
        begin
            upd.count = 16'd1;
            upd.min_x = x_reg; upd.max_x = x_reg;
            upd.min_y = y_reg; upd.max_y = y_reg;
            upd.min_z = z_reg; upd.max_z = z_reg;
            upd.sum_x = xe; upd.sum_z = ze;
        end
        else
        begin
            upd.count = (cm_rdata.count == 16'hFFFF) ? cm_rdata.count
                                                      : cm_rdata.count + 16'd1;
            upd.min_x = ($signed(x_reg) < $signed(cm_rdata.min_x)) ? x_reg : cm_rdata.min_x;
            upd.max_x = ($signed(x_reg) > $signed(cm_rdata.max_x)) ? x_reg : cm_rdata.max_x;
            upd.min_y = ($signed(y_reg) < $signed(cm_rdata.min_y)) ? y_reg : cm_rdata.min_y;
            upd.max_y = ($signed(y_reg) > $signed(cm_rdata.max_y)) ? y_reg : cm_rdata.max_y;
            upd.min_z = ($signed(z_reg) < $signed(cm_rdata.min_z)) ? z_reg : cm_rdata.min_z;
            upd.max_z = ($signed(z_reg) > $signed(cm_rdata.max_z)) ? z_reg : cm_rdata.max_z;
            upd.sum_x = sx;
            upd.sum_z = sz;
        end
    end

    always_comb
    begin
        cm_we    = 1'b0;
        cm_waddr = addr_reg;
        cm_wdata = upd;
        cm_raddr = addr_reg;
        if (state_reg == S_CLEAR)
        begin
            cm_we    = 1'b1;
            cm_waddr = clr_reg;
            cm_wdata = '0;
        end
        else if (state_reg == S_MODIFY)
        begin
            cm_we = 1'b1;
            if (!res_zero_reg)
            begin
                cm_wdata = cm_rdata;
                cm_wdata.count = 16'd0;
            end
        end
    end

    // cell address from row and column
    logic [31:0] bin_addr_w;
    logic [31:0] rd_addr_w;
    assign bin_addr_w = 32'(row_reg) * 32'(NUM_COLS) + 32'(col_q_reg);
    assign rd_addr_w  = 32'(rsel_reg) * 32'(NUM_COLS) + 32'(csel_reg);

    logic z_neg;
    assign z_neg = z_reg[19];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            bval_ok_reg   <= 1'b0;
            srch_done_reg <= 1'b0;
            div_done_reg  <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 16'd1;
                    if (clr_reg == 16'(NCELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg   <= operation;
                        x_reg    <= x_mm;
                        y_reg    <= y_mm;
                        z_reg    <= z_mm;
                        rsel_reg <= row_select;
                        csel_reg <= col_select;
                        res_reg  <= '0;
                        res_zero_reg <= 1'b1;
                        addr_reg <= '0;
                        case (operation)
                            OP_LOAD:
                            begin
                                st_reg <= bnd_we ? ST_OK : ST_INDEX;
                                state_reg <= S_OUT;
                            end
                            OP_BIN:
                            begin
                                idx_reg       <= '0;
                                bval_ok_reg   <= 1'b0;
                                found_reg     <= 1'b0;
                                row_reg       <= '0;
                                srch_done_reg <= 1'b0;
                                div_done_reg  <= 1'b0;
                                state_reg     <= S_SEARCH;
                            end
                            OP_READ:
                            begin
                                state_reg <= S_READ;
                            end
                            default:
                            begin
                                st_reg    <= ST_INDEX;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_SEARCH:
                begin
                    // boundary i is addressed at idx, its data is seen in the cycle after
                    if (!srch_done_reg)
                    begin
                        idx_reg     <= idx_reg + 9'd1;
                        bval_ok_reg <= 1'b1;
                        if (bval_ok_reg)
                        begin
                            if (bnd_rd_reg >= z_reg[18:0])
                            begin
                                found_reg     <= 1'b1;
                                row_reg       <= idx_reg - 9'd1;
                                srch_done_reg <= 1'b1;
                            end
                            else if (idx_reg >= nsearch)
                            begin
                                srch_done_reg <= 1'b1;
                            end
                        end
                        if (z_neg || nsearch == 9'd0)
                        begin
                            srch_done_reg <= 1'b1;
                        end
                    end
                    if (drsp.done)
                    begin
                        div_done_reg   <= 1'b1;
                        col_q_reg      <= drsp.quotient;
                        col_neg_ok_reg <= !diff_s[20] || (neg_diff < {5'd0, colw_reg});
                    end
                    if (srch_done_reg && div_done_reg)
                    begin
                        if (!found_reg)
                        begin
                            row_reg <= '0;
                        end
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    // classify and start the cell read
                    res_zero_reg <= 1'b1;
                    if ($signed({1'b0, zlim_reg}) < $signed(z_reg))
                    begin
                        st_reg    <= ST_ZLIM;
                        state_reg <= S_OUT;
                    end
                    else if (colw_reg == 16'd0 || !col_neg_ok_reg
                             || col_q_reg >= 21'(NUM_COLS)
                             || bin_addr_w >= 32'(CELLS))
                    begin
                        st_reg    <= ST_COL;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        st_reg    <= ST_OK;
                        addr_reg  <= bin_addr_w[15:0];
                        state_reg <= S_READ;
                        op_reg    <= OP_BIN;
                    end
                end
                S_READ:
                begin
                    if (op_reg == OP_READ)
                    begin
                        if (32'(rsel_reg) >= 32'(NUM_ROWS)
                            || 32'(csel_reg) >= 32'(NUM_COLS)
                            || rd_addr_w >= 32'(CELLS))
                        begin
                            st_reg    <= ST_INDEX;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            st_reg    <= ST_OK;
                            addr_reg  <= rd_addr_w[15:0];
                            op_reg    <= OP_BIN;
                            // re-enter as a read with address set
                            state_reg <= S_READ;
                            csel_reg  <= 8'hFF;
                            rsel_reg  <= 8'hFF;
                            res_zero_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_MODIFY;
                    end
                end
                S_MODIFY:
                begin
                    if (!res_zero_reg)
                    begin
                        res_reg <= (cm_rdata.count == 16'd0) ? '0 : cm_rdata;
                    end
                    else
                    begin
                        res_reg <= upd;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    else if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // read-and-clear path: op_reg forced to bin after address check, so the
    // write-back picks the clearing word through res_zero_reg instead
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status = st_reg;
    assign cell_address = (st_reg == ST_OK) ? addr_reg : 16'd0;
    assign point_count = res_reg.count;
    assign min_x_out = res_reg.min_x;
    assign max_x_out = res_reg.max_x;
    assign min_y_out = res_reg.min_y;
    assign max_y_out = res_reg.max_y;
    assign min_z_out = res_reg.min_z;
    assign max_z_out = res_reg.max_z;
    assign sum_x_out = res_reg.sum_x;
    assign sum_z_out = res_reg.sum_z;
endmodule
`default_nettype wire
